@@ src/ofmr_pkg.sv @@
// Package for the opcode framed message receiver.
// Holds the beat payload types, the receiver state type and the fixed codes.
// Has no dependencies.
package ofmr_pkg;

    localparam logic [7:0] OPCODE_MIN    = 8'h80;
    localparam logic [7:0] CSUM_INVERT   = 8'hFF;
    localparam logic [6:0] LEN_MASK      = 7'h7F;
    localparam logic [1:0] LEN_SEL_LONG  = 2'b11;
    localparam int         REPLY_BIT     = 3;
    localparam logic [7:0] REPLY_OP_A    = 8'hB4;
    localparam logic [7:0] REPLY_OP_B    = 8'hE7;
    localparam logic [7:0] REPLY_OP_C    = 8'h81;

    localparam logic [7:0] ERR_INCOMPLETE = 8'h10;
    localparam logic [7:0] ERR_CHECKSUM   = 8'h20;
    localparam logic [7:0] ERR_STRAY      = 8'h40;
    localparam logic [7:0] ERR_OVERFLOW   = 8'h80;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       line_collision;
        logic       line_timeout;
        logic       line_framing_error;
        logic       line_carrier_loss;
        logic       byte_is_echo;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] data_out;
        logic [6:0] byte_index;
        logic       starts_message;
        logic       message_done;
        logic [7:0] message_length;
        logic [7:0] error_bits;
        logic       message_echo;
        logic       answers_request;
    } out_beat_t;

    typedef struct packed {
        logic       collecting;
        logic [7:0] position;
        logic [7:0] expected_length;
        logic [7:0] running_xor;
        logic [7:0] current_opcode;
        logic       acc_echo;
    } rx_state_t;

    localparam rx_state_t RX_STATE_IDLE = '{
        collecting: 1'b0, position: 8'd0, expected_length: 8'd0,
        running_xor: 8'd0, current_opcode: 8'd0, acc_echo: 1'b0};

endpackage

@@ src/ofmr_step.sv @@
// Per-beat framing logic: next receiver state and the result for one byte.
// Depends on ofmr_pkg.
module ofmr_step #(
    parameter int MAX_MESSAGE_LENGTH = 128
) (
    input  ofmr_pkg::rx_state_t state,
    input  ofmr_pkg::in_beat_t  beat,
    input  logic [7:0]          last_sent_opcode,
    output ofmr_pkg::rx_state_t state_next,
    output ofmr_pkg::out_beat_t result
);

    localparam logic [7:0] MAX_LEN = 8'(MAX_MESSAGE_LENGTH);

    logic [3:0] line;
    logic [7:0] b;
    logic [7:0] pos_inc;
    logic [7:0] exp_eff;
    logic       echo_acc;
    logic       is_reply;

    always_comb begin
        b        = beat.rx_byte;
        line     = {beat.line_carrier_loss, beat.line_framing_error,
                    beat.line_timeout, beat.line_collision};
        pos_inc  = state.position + 8'd1;
        exp_eff  = (state.position == 8'd1 &&
                    state.current_opcode[6:5] == ofmr_pkg::LEN_SEL_LONG)
                   ? {1'b0, b[6:0] & ofmr_pkg::LEN_MASK} : state.expected_length;
        echo_acc = state.acc_echo | beat.byte_is_echo;
        is_reply = state.current_opcode == ofmr_pkg::REPLY_OP_A ||
                   state.current_opcode == ofmr_pkg::REPLY_OP_B ||
                   state.current_opcode == ofmr_pkg::REPLY_OP_C;

        state_next = state;
        result     = '0;
        result.data_out = b;

        priority if (line != 4'd0) begin
            result.byte_index     = state.collecting ? state.position[6:0] : 7'd0;
            result.message_done   = 1'b1;
            result.message_length = state.collecting ? pos_inc : 8'd1;
            result.error_bits     = {4'd0, line} | ofmr_pkg::ERR_INCOMPLETE |
                                    ofmr_pkg::ERR_CHECKSUM;
            result.message_echo   = beat.byte_is_echo |
                                    (state.collecting & state.acc_echo);
            state_next = ofmr_pkg::RX_STATE_IDLE;
        end else if (b >= ofmr_pkg::OPCODE_MIN) begin
            if (state.collecting) begin
                result.message_done   = 1'b1;
                result.message_length = state.position;
                result.error_bits     = ofmr_pkg::ERR_INCOMPLETE | ofmr_pkg::ERR_CHECKSUM;
                result.message_echo   = state.acc_echo;
            end
            result.starts_message      = 1'b1;
            state_next.collecting      = 1'b1;
            state_next.position        = 8'd1;
            state_next.running_xor     = b;
            state_next.current_opcode  = b;
            state_next.acc_echo        = beat.byte_is_echo;
            unique case (b[6:5])
                2'd0:    state_next.expected_length = 8'd2;
                2'd1:    state_next.expected_length = 8'd4;
                2'd2:    state_next.expected_length = 8'd6;
                default: state_next.expected_length = 8'd0;
            endcase
        end else if (state.collecting) begin
            result.byte_index = state.position[6:0];
            if (pos_inc == exp_eff) begin
                result.message_done    = 1'b1;
                result.message_length  = pos_inc;
                result.error_bits      = ((state.running_xor ^ ofmr_pkg::CSUM_INVERT) != b)
                                         ? ofmr_pkg::ERR_CHECKSUM : 8'd0;
                result.message_echo    = echo_acc;
                result.answers_request = echo_acc |
                                         (last_sent_opcode[ofmr_pkg::REPLY_BIT] & is_reply);
                state_next = ofmr_pkg::RX_STATE_IDLE;
            end else if (pos_inc >= MAX_LEN) begin
                result.message_done   = 1'b1;
                result.message_length = pos_inc;
                result.error_bits     = ofmr_pkg::ERR_OVERFLOW | ofmr_pkg::ERR_INCOMPLETE;
                result.message_echo   = echo_acc;
                state_next = ofmr_pkg::RX_STATE_IDLE;
            end else begin
                state_next.position        = pos_inc;
                state_next.expected_length = exp_eff;
                state_next.acc_echo        = echo_acc;
                state_next.running_xor     = state.running_xor ^ b;
            end
        end else begin
            result.message_done   = 1'b1;
            result.message_length = 8'd1;
            result.error_bits     = ofmr_pkg::ERR_STRAY;
            result.message_echo   = beat.byte_is_echo;
        end
    end

endmodule

@@ src/opcode_framed_message_receiver.sv @@
// Top level of the opcode framed message receiver: state, config register, output skid.
// Depends on ofmr_pkg and ofmr_step.
// The result of each accepted input beat is registered before it appears on m_data.
// Throughput: one beat per cycle while the skid entry is empty; a two-entry
// output stage keeps s_ready high for one extra beat while a result waits on m_ready.
// Reset: synchronous, active low; returns to idle and clears last_sent_opcode.
module opcode_framed_message_receiver #(
    parameter int MAX_MESSAGE_LENGTH = 128
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ofmr_pkg::in_beat_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ofmr_pkg::out_beat_t m_data,
    input  logic                cfg_wr_en,
    input  logic [7:0]          cfg_wr_data
);

    ofmr_pkg::rx_state_t state_reg, state_next;
    ofmr_pkg::out_beat_t result_next;
    ofmr_pkg::out_beat_t main_reg, skid_reg;
    logic                main_valid_reg, skid_valid_reg;
    logic [7:0]          last_sent_reg;
    logic                s_accept;
    logic                m_pop;

    ofmr_step #(.MAX_MESSAGE_LENGTH(MAX_MESSAGE_LENGTH)) u_step (
        .state            (state_reg),
        .beat             (s_data),
        .last_sent_opcode (last_sent_reg),
        .state_next       (state_next),
        .result           (result_next)
    );

    assign s_ready  = !skid_valid_reg;
    assign s_accept = s_valid && s_ready;
    assign m_valid  = main_valid_reg;
    assign m_data   = main_reg;
    assign m_pop    = main_valid_reg && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ofmr_pkg::RX_STATE_IDLE;
            last_sent_reg <= 8'd0;
        end else begin
            if (s_accept) begin
                state_reg <= state_next;
            end
            if (cfg_wr_en) begin
                last_sent_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (m_pop) begin
            if (skid_valid_reg) begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                main_valid_reg <= s_accept;
            end
        end else if (!main_valid_reg) begin
            main_valid_reg <= s_accept;
        end else if (s_accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_pop && skid_valid_reg) begin
            main_reg <= skid_reg;
        end else if (s_accept && (m_pop || !main_valid_reg)) begin
            main_reg <= result_next;
        end
        if (s_accept && main_valid_reg && !m_pop) begin
            skid_reg <= result_next;
        end
    end

    a_skid_needs_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("Skid entry held while the main output entry is empty.");

    a_accept_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> m_valid)
        else $error("An accepted beat produced no result beat.");

    a_idle_state_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !state_reg.collecting |-> (state_reg.position == 8'd0 && !state_reg.acc_echo))
        else $error("Idle receiver holds message position or echo state.");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("Stalled result beat changed or was dropped.");

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for opcode_framed_message_receiver: a directed table, then random
// noisy framed messages, checked beat by beat against set results or a deframing predictor.
// Depends on ofmr_pkg and the receiver RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_LEN      = 128;
    localparam int RANDOM_BEATS = 2000;
    localparam int PHASE_BEATS  = 250;
    localparam logic [7:0] LEN_SHORT  = 8'd2;
    localparam logic [7:0] LEN_MEDIUM = 8'd4;
    localparam logic [7:0] LEN_LONG   = 8'd6;
    localparam logic [3:0] LINE_OK    = 4'h0;

    typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t           kind;
        ofmr_pkg::in_beat_t  beat;
        int                  reps;
        logic                typed;
        ofmr_pkg::out_beat_t result;
        logic [7:0]          cfg;
    } script_row_t;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    ofmr_pkg::in_beat_t  s_data;
    logic                m_valid;
    logic                m_ready;
    ofmr_pkg::out_beat_t m_data;
    logic                cfg_wr_en;
    logic [7:0]          cfg_wr_data;

    ofmr_pkg::out_beat_t awaited_beats[$];
    script_row_t         script[$];

    logic       rcv_collecting;
    logic [7:0] rcv_pos;
    logic [7:0] rcv_len;
    logic [7:0] rcv_xor;
    logic [7:0] rcv_op;
    logic       rcv_echo;
    logic [7:0] last_sent_op;

    int  mismatch_count = 0;
    int  sent_beats = 0;
    int  random_beats = 0;
    int  ended_messages = 0;
    int  overflows = 0;
    int  cfg_writes = 0;
    int  result_count = 0;
    int  stall_left = 0;
    bit  quiet = 0;

    opcode_framed_message_receiver #(
        .MAX_MESSAGE_LENGTH(MAX_LEN)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    function automatic int idle_cycles();
        int r;
        if (quiet) begin
            return 0;
        end
        r = int'($urandom_range(0, 99));
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return int'($urandom_range(1, 3));
        end
        return int'($urandom_range(10, 30));
    endfunction

    function automatic ofmr_pkg::in_beat_t mk_beat(input logic [7:0] v, input logic [3:0] line,
                                                   input logic echo);
        ofmr_pkg::in_beat_t b;
        b.rx_byte            = v;
        b.line_collision     = line[0];
        b.line_timeout       = line[1];
        b.line_framing_error = line[2];
        b.line_carrier_loss  = line[3];
        b.byte_is_echo       = echo;
        return b;
    endfunction

    function automatic ofmr_pkg::out_beat_t mk_result(input logic [7:0] data,
                                                      input logic [6:0] idx,
                                                      input logic start, input logic done,
                                                      input logic [7:0] len,
                                                      input logic [7:0] err,
                                                      input logic echo, input logic ans);
        ofmr_pkg::out_beat_t r;
        r.data_out        = data;
        r.byte_index      = idx;
        r.starts_message  = start;
        r.message_done    = done;
        r.message_length  = len;
        r.error_bits      = err;
        r.message_echo    = echo;
        r.answers_request = ans;
        return r;
    endfunction

    function automatic void clear_frame();
        rcv_collecting = 1'b0;
        rcv_pos        = 8'd0;
        rcv_len        = 8'd0;
        rcv_xor        = 8'd0;
        rcv_op         = 8'd0;
        rcv_echo       = 1'b0;
    endfunction

    function automatic ofmr_pkg::out_beat_t deframe_beat(input ofmr_pkg::in_beat_t b);
        ofmr_pkg::out_beat_t r;
        logic [3:0]          line;
        logic                reply;
        r = '0;
        r.data_out = b.rx_byte;
        line = {b.line_carrier_loss, b.line_framing_error, b.line_timeout, b.line_collision};
        if (line != LINE_OK) begin
            r.message_done   = 1'b1;
            r.byte_index     = rcv_collecting ? rcv_pos[6:0] : 7'd0;
            r.message_length = rcv_collecting ? rcv_pos + 8'd1 : 8'd1;
            r.error_bits     = {4'd0, line} | ofmr_pkg::ERR_INCOMPLETE | ofmr_pkg::ERR_CHECKSUM;
            r.message_echo   = b.byte_is_echo | (rcv_collecting & rcv_echo);
            clear_frame();
        end else if (b.rx_byte >= ofmr_pkg::OPCODE_MIN) begin
            if (rcv_collecting) begin
                r.message_done   = 1'b1;
                r.message_length = rcv_pos;
                r.error_bits     = ofmr_pkg::ERR_INCOMPLETE | ofmr_pkg::ERR_CHECKSUM;
                r.message_echo   = rcv_echo;
            end
            r.starts_message = 1'b1;
            rcv_collecting   = 1'b1;
            rcv_pos          = 8'd1;
            rcv_xor          = b.rx_byte;
            rcv_op           = b.rx_byte;
            rcv_echo         = b.byte_is_echo;
            unique case (b.rx_byte[6:5])
                2'd0: rcv_len = LEN_SHORT;
                2'd1: rcv_len = LEN_MEDIUM;
                2'd2: rcv_len = LEN_LONG;
                default: rcv_len = 8'd0;
            endcase
        end else if (rcv_collecting) begin
            r.byte_index = rcv_pos[6:0];
            if (rcv_pos == 8'd1 && rcv_op[6:5] == ofmr_pkg::LEN_SEL_LONG) begin
                rcv_len = {1'b0, b.rx_byte[6:0] & ofmr_pkg::LEN_MASK};
            end
            rcv_pos  = rcv_pos + 8'd1;
            rcv_echo = rcv_echo | b.byte_is_echo;
            if (rcv_pos == rcv_len) begin
                reply = (rcv_op == ofmr_pkg::REPLY_OP_A) || (rcv_op == ofmr_pkg::REPLY_OP_B) ||
                        (rcv_op == ofmr_pkg::REPLY_OP_C);
                r.message_done    = 1'b1;
                r.message_length  = rcv_pos;
                r.error_bits      = ((rcv_xor ^ ofmr_pkg::CSUM_INVERT) != b.rx_byte)
                                    ? ofmr_pkg::ERR_CHECKSUM : 8'd0;
                r.message_echo    = rcv_echo;
                r.answers_request = rcv_echo | (last_sent_op[ofmr_pkg::REPLY_BIT] & reply);
                clear_frame();
            end else if (rcv_pos >= MAX_LEN) begin
                r.message_done   = 1'b1;
                r.message_length = rcv_pos;
                r.error_bits     = ofmr_pkg::ERR_OVERFLOW | ofmr_pkg::ERR_INCOMPLETE;
                r.message_echo   = rcv_echo;
                clear_frame();
            end else begin
                rcv_xor = rcv_xor ^ b.rx_byte;
            end
        end else begin
            r.message_done   = 1'b1;
            r.message_length = 8'd1;
            r.error_bits     = ofmr_pkg::ERR_STRAY;
            r.message_echo   = b.byte_is_echo;
        end
        return r;
    endfunction

    task automatic log_mismatch(input string what, input logic [63:0] got,
                                input logic [63:0] want);
        $display("MISMATCH at result %0d, %s: got 0x%0h, expected 0x%0h",
                 result_count, what, got, want);
        mismatch_count++;
    endtask

    task automatic send_beat(input ofmr_pkg::in_beat_t b, input logic typed,
                             input ofmr_pkg::out_beat_t want);
        int                  gap;
        ofmr_pkg::out_beat_t predicted;
        gap = idle_cycles();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        do @(posedge aclk); while (!s_ready);
        predicted = deframe_beat(b);
        awaited_beats.push_back(typed ? want : predicted);
        sent_beats++;
        if (predicted.message_done) begin
            ended_messages++;
        end
        if ((predicted.error_bits & ofmr_pkg::ERR_OVERFLOW) != 0) begin
            overflows++;
        end
    endtask

    task automatic write_config(input logic [7:0] v);
        s_valid <= 1'b0;
        while (awaited_beats.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en    <= 1'b0;
        last_sent_op = v;
        cfg_writes++;
    endtask

    task automatic send_random_message();
        ofmr_pkg::in_beat_t msg[$];
        logic [7:0]         op;
        logic [7:0]         lenb;
        logic [7:0]         xsum;
        logic [7:0]         v;
        logic [3:0]         line;
        logic               all_echo;
        logic               checked;
        int                 total;
        int                 count;
        int                 r;
        if ($urandom_range(0, 9) == 0) begin
            msg.push_back(mk_beat(8'($urandom_range(0, 127)), LINE_OK,
                                  1'($urandom_range(0, 1))));
        end
        r = int'($urandom_range(0, 11));
        unique case (r)
            0: op = ofmr_pkg::REPLY_OP_A;
            1: op = ofmr_pkg::REPLY_OP_B;
            2: op = ofmr_pkg::REPLY_OP_C;
            default: op = 8'($urandom_range(128, 255));
        endcase
        lenb    = 8'd0;
        checked = 1'b1;
        unique case (op[6:5])
            2'd0: total = int'(LEN_SHORT);
            2'd1: total = int'(LEN_MEDIUM);
            2'd2: total = int'(LEN_LONG);
            default: begin
                r = int'($urandom_range(0, 99));
                if (r < 2) begin
                    lenb = 8'($urandom_range(0, 1));
                end else if (r < 6) begin
                    lenb = 8'($urandom_range(64, 127));
                end else begin
                    lenb = 8'($urandom_range(2, 12));
                end
                checked = (lenb >= 8'd2);
                total   = checked ? int'(lenb) : MAX_LEN;
            end
        endcase
        all_echo = ($urandom_range(0, 4) == 0);
        msg.push_back(mk_beat(op, LINE_OK, all_echo));
        xsum = op;
        for (int i = 1; i < total; i++) begin
            if (i == 1 && op[6:5] == ofmr_pkg::LEN_SEL_LONG) begin
                v = lenb;
            end else if (i == total - 1 && checked) begin
                v = xsum ^ ofmr_pkg::CSUM_INVERT;
                if ($urandom_range(0, 9) == 0) begin
                    v = v ^ 8'($urandom_range(1, 127));
                end
            end else begin
                v = 8'($urandom_range(0, 127));
            end
            xsum = xsum ^ v;
            line = ($urandom_range(0, 59) == 0) ? 4'($urandom_range(1, 15)) : LINE_OK;
            msg.push_back(mk_beat(v, line, all_echo | ($urandom_range(0, 39) == 0)));
        end
        count = msg.size();
        if ($urandom_range(0, 11) == 0) begin
            count = int'($urandom_range(1, msg.size() - 1));
        end
        for (int i = 0; i < count; i++) begin
            send_beat(msg[i], 1'b0, '0);
            random_beats++;
        end
    endtask

    task automatic add_beat(input logic [7:0] v, input logic [3:0] line, input logic echo,
                            input int reps);
        script.push_back('{ROW_BEAT, mk_beat(v, line, echo), reps, 1'b0, '0, 8'd0});
    endtask

    task automatic add_known(input logic [7:0] v, input logic [3:0] line, input logic echo,
                             input ofmr_pkg::out_beat_t want);
        script.push_back('{ROW_BEAT, mk_beat(v, line, echo), 1, 1'b1, want, 8'd0});
    endtask

    task automatic add_cfg(input logic [7:0] v);
        script.push_back('{ROW_CFG, '0, 0, 1'b0, '0, v});
    endtask

    always @(posedge aclk) begin : result_side
        ofmr_pkg::out_beat_t want;
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            m_ready <= 1'b1;
            stall_left = idle_cycles();
        end
        if (aresetn && m_valid && m_ready) begin
            if (awaited_beats.size() == 0) begin
                log_mismatch("result with nothing awaited", 64'(m_data), 64'd0);
            end else begin
                want = awaited_beats.pop_front();
                if (m_data.data_out !== want.data_out)
                    log_mismatch("data_out", 64'(m_data.data_out), 64'(want.data_out));
                if (m_data.byte_index !== want.byte_index)
                    log_mismatch("byte_index", 64'(m_data.byte_index), 64'(want.byte_index));
                if (m_data.starts_message !== want.starts_message)
                    log_mismatch("starts_message", 64'(m_data.starts_message),
                                 64'(want.starts_message));
                if (m_data.message_done !== want.message_done)
                    log_mismatch("message_done", 64'(m_data.message_done),
                                 64'(want.message_done));
                if (m_data.message_length !== want.message_length)
                    log_mismatch("message_length", 64'(m_data.message_length),
                                 64'(want.message_length));
                if (m_data.error_bits !== want.error_bits)
                    log_mismatch("error_bits", 64'(m_data.error_bits), 64'(want.error_bits));
                if (m_data.message_echo !== want.message_echo)
                    log_mismatch("message_echo", 64'(m_data.message_echo),
                                 64'(want.message_echo));
                if (m_data.answers_request !== want.answers_request)
                    log_mismatch("answers_request", 64'(m_data.answers_request),
                                 64'(want.answers_request));
            end
            result_count++;
        end
    end

    initial begin
        #10_000_000;
        $display("Timeout with %0d results still awaited", awaited_beats.size());
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int phase;
        int phase_end;
        int directed_beats;
        logic [7:0] setting;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = 8'd0;
        last_sent_op = 8'd0;
        clear_frame();

        add_cfg(8'h00);
        add_known(8'h00, LINE_OK, 1'b0,
                  mk_result(8'h00, 7'd0, 1'b0, 1'b1, 8'd1, ofmr_pkg::ERR_STRAY, 1'b0, 1'b0));
        add_known(8'hFF, 4'hF, 1'b1,
                  mk_result(8'hFF, 7'd0, 1'b0, 1'b1, 8'd1,
                            8'h0F | ofmr_pkg::ERR_INCOMPLETE | ofmr_pkg::ERR_CHECKSUM,
                            1'b1, 1'b0));
        add_known(8'h80, LINE_OK, 1'b0,
                  mk_result(8'h80, 7'd0, 1'b1, 1'b0, 8'd0, 8'd0, 1'b0, 1'b0));
        add_known(8'h7F, LINE_OK, 1'b0,
                  mk_result(8'h7F, 7'd1, 1'b0, 1'b1, 8'd2, 8'd0, 1'b0, 1'b0));
        add_beat(8'hA0, LINE_OK, 1'b1, 1);
        add_beat(8'h11, LINE_OK, 1'b0, 1);
        add_beat(8'h22, LINE_OK, 1'b0, 1);
        add_beat(8'h6C, LINE_OK, 1'b0, 1);
        add_beat(8'hC0, LINE_OK, 1'b0, 1);
        add_beat(8'h05, LINE_OK, 1'b1, 1);
        add_beat(8'hE0, LINE_OK, 1'b0, 1);
        add_beat(8'h03, LINE_OK, 1'b0, 1);
        add_beat(8'h1C, LINE_OK, 1'b0, 1);
        add_beat(8'h7F, LINE_OK, 1'b1, 1);
        add_cfg(8'h08);
        add_beat(8'hB4, LINE_OK, 1'b0, 1);
        add_beat(8'h01, LINE_OK, 1'b0, 1);
        add_beat(8'h02, LINE_OK, 1'b0, 1);
        add_beat(8'h48, LINE_OK, 1'b0, 1);
        add_beat(8'h81, LINE_OK, 1'b0, 1);
        add_beat(8'h00, LINE_OK, 1'b0, 1);
        add_beat(8'hE7, LINE_OK, 1'b0, 1);
        add_beat(8'h01, LINE_OK, 1'b0, 1);
        add_beat(8'h00, LINE_OK, 1'b0, MAX_LEN - 2);
        add_beat(8'hF0, LINE_OK, 1'b0, 1);
        add_beat(8'h00, LINE_OK, 1'b0, 1);
        add_beat(8'h05, 4'h1, 1'b0, 1);
        add_beat(8'h9F, LINE_OK, 1'b1, 1);
        add_beat(8'h90, 4'h2, 1'b0, 1);

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (script[i]) begin
            if (script[i].kind == ROW_CFG) begin
                write_config(script[i].cfg);
            end else begin
                repeat (script[i].reps) send_beat(script[i].beat, script[i].typed,
                                                  script[i].result);
            end
        end
        directed_beats = sent_beats;

        phase = 0;
        while (random_beats < RANDOM_BEATS) begin
            unique case (phase % 5)
                0: setting = 8'h08;
                1: setting = 8'hFF;
                2: setting = 8'h00;
                3: setting = 8'hF7;
                default: setting = 8'($urandom_range(0, 255));
            endcase
            write_config(setting);
            quiet = (phase % 4 == 3);
            phase_end = random_beats + PHASE_BEATS;
            while (random_beats < phase_end) send_random_message();
            phase++;
        end
        quiet = 0;

        s_valid <= 1'b0;
        while (awaited_beats.size() != 0) @(posedge aclk);
        repeat (5) @(posedge aclk);

        $display("Sent %0d beats (%0d directed) over %0d register settings;",
                 sent_beats, directed_beats, cfg_writes);
        $display("%0d messages ended, %0d by overflow, %0d results checked.",
                 ended_messages, overflows, result_count);
        if (mismatch_count == 0 && awaited_beats.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
src/ofmr_pkg.sv
src/ofmr_step.sv
src/opcode_framed_message_receiver.sv
tb/testbench.sv
